// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is asserted.
`define SSM_ASSERT(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// Clocked property that also holds through reset.
`define SSM_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

// ----- rtl/core/ssm_pkg.sv -----
// Package: shared types and constants of the sender sequence monitor.
package ssm_pkg;

  localparam int unsigned ID_W      = 32;
  localparam int unsigned SEQ_W     = 31;
  localparam int unsigned TIME_W    = 48;
  localparam int unsigned DLY_W     = 49;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CNT_OUT_W = 5;

  localparam logic [CFG_W-1:0] USEC_PER_SEC      = 32'd1000000;
  localparam logic [CFG_W-1:0] INTER_LIMIT_RST   = 32'd100000;
  localparam logic [CFG_W-1:0] TRANSIT_LIMIT_RST = 32'd100000;
  localparam logic [CFG_W-1:0] AGE_LIMIT_RST     = 32'(10 * USEC_PER_SEC);

  localparam logic [CFG_IDX_W-1:0] REG_INTER_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRANSIT_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AGE_LIMIT     = 2'd2;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_DUP   = 3'd1,
    ST_BACK  = 3'd2,
    ST_GAP   = 3'd3,
    ST_FIRST = 3'd4,
    ST_FULL  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_CALC,
    S_FIN
  } state_t;

  // Commands from the sequencer to the connection table.
  typedef struct packed {
    logic start;
    logic wr_en;
  } tbl_ctl_t;

  // Scan status from the connection table.
  typedef struct packed {
    logic busy;
    logic hit;
    logic free;
  } tbl_stat_t;

endpackage

// ----- rtl/core/ssm_intf.sv -----
// Interfaces: message header channel and result channel.
interface ssm_in_if import ssm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ID_W-1:0]   sender_id;
  logic [SEQ_W-1:0]  seq_number;
  logic [TIME_W-1:0] msg_time;
  logic [TIME_W-1:0] rcv_time;

  modport source(output valid, sender_id, seq_number, msg_time, rcv_time, input ready);
  modport sink(input valid, sender_id, seq_number, msg_time, rcv_time, output ready);
endinterface

interface ssm_out_if import ssm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [2:0]           status;
  logic                 updated;
  logic [DLY_W-1:0]     transit_delay;
  logic [DLY_W-1:0]     inter_delay;
  logic                 transit_late;
  logic                 inter_late;
  logic [CNT_OUT_W-1:0] purged_count;
  logic [CNT_OUT_W-1:0] connections;

  modport source(output valid, status, updated, transit_delay, inter_delay, transit_late,
                 inter_late, purged_count, connections, input ready);
  modport sink(input valid, status, updated, transit_delay, inter_delay, transit_late,
               inter_late, purged_count, connections, output ready);
endinterface

// ----- rtl/core/sender_sequence_monitor.sv -----
// Top level: per-sender sequence number and delay monitor.
//
//   channel   dir  handshake         carries
//   in_msg    in   valid/ready       sender_id, seq_number, msg_time, rcv_time
//   out_res   out  valid/ready       status, updated, delays, late flags, counts
//   cfg_*     in   cfg_wr_en strobe  cfg_idx selects limit, cfg_wdata value
//
// A transaction is held from accept to result by the linear scan of the entry
// memory, one read per cycle, and then by the calc and final steps.
// in_msg.ready is high only in idle, also while a result waits on out_res.
// A stalled out_res holds the sequencer in its final step; nothing is written
// back to the table until the result register is free.
// rst_n is synchronous: valid bits, counters and limits return to reset.
module sender_sequence_monitor import ssm_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned ID_BITS     = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  ssm_in_if.sink               in_msg,
  ssm_out_if.source            out_res,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  // Only the low ID_BITS of the sender label take part in the match.
  localparam int unsigned KEY_W = (ID_BITS < ID_W) ? ID_BITS : ID_W;
  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

  // Limit registers
  logic [CFG_W-1:0] inter_lim_r;
  logic [CFG_W-1:0] transit_lim_r;
  logic [CFG_W-1:0] age_lim_r;

  // Sequencer
  state_t state_r;
  state_t state_nxt;

  // Latched message header
  logic [KEY_W-1:0]  key_r;
  logic [SEQ_W-1:0]  seq_r;
  logic [TIME_W-1:0] mt_r;
  logic [TIME_W-1:0] rt_r;

  // Differences, registered in the calc step
  logic [SEQ_W:0]   seq_diff_r;
  logic [DLY_W-1:0] transit_r;
  logic [DLY_W-1:0] inter_r;

  // Result register
  logic                 out_valid_r;
  status_t              status_r;
  logic                 updated_r;
  logic [DLY_W-1:0]     transit_out_r;
  logic [DLY_W-1:0]     inter_out_r;
  logic                 transit_late_r;
  logic                 inter_late_r;
  logic [CNT_OUT_W-1:0] purged_out_r;
  logic [CNT_OUT_W-1:0] conn_out_r;

  // Table link
  tbl_ctl_t          tctl;
  tbl_stat_t         tstat;
  logic [IDX_W-1:0]  hit_idx;
  logic [SEQ_W-1:0]  hit_seq;
  logic [TIME_W-1:0] hit_time;
  logic [IDX_W-1:0]  free_idx;
  logic [CNT_W-1:0]  purged;
  logic [CNT_W-1:0]  live;

  // Final-step decision
  logic             in_acc;
  logic             fin_go;
  status_t          status_c;
  logic             upd_c;
  logic             show_transit;
  logic             show_inter;
  logic             transit_late_c;
  logic             inter_late_c;
  logic [CNT_W-1:0] conn_c;

  assign in_acc = in_msg.valid && in_msg.ready;
  assign fin_go = (state_r == S_FIN) && (!out_valid_r || out_res.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inter_lim_r   <= INTER_LIMIT_RST;
      transit_lim_r <= TRANSIT_LIMIT_RST;
      age_lim_r     <= AGE_LIMIT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_idx)
        REG_INTER_LIMIT:   inter_lim_r   <= cfg_wdata;
        REG_TRANSIT_LIMIT: transit_lim_r <= cfg_wdata;
        REG_AGE_LIMIT:     age_lim_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_msg.valid) state_nxt = S_SCAN;
      S_SCAN: if (!tstat.busy) state_nxt = S_CALC;
      S_CALC: state_nxt = S_FIN;
      S_FIN:  if (fin_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequencer outputs
  always_comb begin
    in_msg.ready = (state_r == S_IDLE);
    tctl.start   = in_acc;
    tctl.wr_en   = fin_go && upd_c;
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      key_r <= in_msg.sender_id[KEY_W-1:0];
      seq_r <= in_msg.seq_number;
      mt_r  <= in_msg.msg_time;
      rt_r  <= in_msg.rcv_time;
    end
    if (state_r == S_CALC) begin
      seq_diff_r <= {1'b0, seq_r} - {1'b0, hit_seq};
      transit_r  <= {1'b0, rt_r} - {1'b0, mt_r};
      inter_r    <= {1'b0, mt_r} - {1'b0, hit_time};
    end
  end

  ssm_table #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_W       (KEY_W)
  ) u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (tctl),
    .key       (key_r),
    .rcv_time  (rt_r),
    .age_limit (age_lim_r),
    .wr_idx    (tstat.hit ? hit_idx : free_idx),
    .wr_seq    (seq_r),
    .wr_time   (mt_r),
    .stat      (tstat),
    .hit_idx   (hit_idx),
    .hit_seq   (hit_seq),
    .hit_time  (hit_time),
    .free_idx  (free_idx),
    .purged    (purged),
    .live      (live)
  );

  // Classification. Known sender: sign and value of the sequence step.
  // Unknown sender: created in the first free slot unless the table is full.
  always_comb begin
    status_c     = ST_OK;
    upd_c        = 1'b0;
    show_transit = 1'b0;
    show_inter   = 1'b0;
    conn_c       = live;
    if (tstat.hit) begin
      if (seq_diff_r == (SEQ_W+1)'(1)) begin
        status_c = ST_OK;
      end else if (seq_diff_r == '0) begin
        status_c = ST_DUP;
      end else if (seq_diff_r[SEQ_W]) begin
        status_c = ST_BACK;
      end else begin
        status_c = ST_GAP;
      end
      upd_c        = (status_c == ST_OK) || (status_c == ST_GAP);
      show_transit = upd_c;
      show_inter   = upd_c;
    end else if (!tstat.free) begin
      status_c = ST_FULL;
    end else begin
      upd_c  = 1'b1;
      conn_c = live + CNT_W'(1);
      if (live == '0) begin
        // first entry into an empty table is not checked
        status_c = ST_FIRST;
      end else begin
        status_c     = (seq_r == SEQ_W'(1)) ? ST_OK : ST_GAP;
        show_transit = 1'b1;
      end
    end
    transit_late_c = show_transit &&
                     ($signed(transit_r) > $signed({{(DLY_W-CFG_W){1'b0}}, transit_lim_r}));
    inter_late_c   = show_inter &&
                     ($signed(inter_r) > $signed({{(DLY_W-CFG_W){1'b0}}, inter_lim_r}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_go) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      status_r       <= status_c;
      updated_r      <= upd_c;
      transit_out_r  <= show_transit ? transit_r : '0;
      inter_out_r    <= show_inter ? inter_r : '0;
      transit_late_r <= transit_late_c;
      inter_late_r   <= inter_late_c;
      purged_out_r   <= CNT_OUT_W'(purged);
      conn_out_r     <= CNT_OUT_W'(conn_c);
    end
  end

  assign out_res.valid         = out_valid_r;
  assign out_res.status        = status_r;
  assign out_res.updated       = updated_r;
  assign out_res.transit_delay = transit_out_r;
  assign out_res.inter_delay   = inter_out_r;
  assign out_res.transit_late  = transit_late_r;
  assign out_res.inter_late    = inter_late_r;
  assign out_res.purged_count  = purged_out_r;
  assign out_res.connections   = conn_out_r;

endmodule

// ----- rtl/core/ssm_table.sv -----
// Connection table: entry memory, valid bits, aging and lookup scan.
module ssm_table import ssm_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 16,
  parameter int unsigned KEY_W       = 32,
  localparam int unsigned IDX_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int unsigned CNT_W      = $clog2(TABLE_DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  tbl_ctl_t          ctl,
  input  logic [KEY_W-1:0]  key,
  input  logic [TIME_W-1:0] rcv_time,
  input  logic [CFG_W-1:0]  age_limit,
  input  logic [IDX_W-1:0]  wr_idx,
  input  logic [SEQ_W-1:0]  wr_seq,
  input  logic [TIME_W-1:0] wr_time,
  output tbl_stat_t         stat,
  output logic [IDX_W-1:0]  hit_idx,
  output logic [SEQ_W-1:0]  hit_seq,
  output logic [TIME_W-1:0] hit_time,
  output logic [IDX_W-1:0]  free_idx,
  output logic [CNT_W-1:0]  purged,
  output logic [CNT_W-1:0]  live
);

  localparam int unsigned ENT_W = KEY_W + SEQ_W + TIME_W;

  logic [ENT_W-1:0]       mem [TABLE_DEPTH];
  logic [ENT_W-1:0]       rd_data_r;
  logic [TABLE_DEPTH-1:0] valid_r;

  logic                   scan_r;
  logic [CNT_W-1:0]       iss_cnt_r;
  logic                   pend_r;
  logic [IDX_W-1:0]       pidx_r;

  logic                   hit_r;
  logic                   free_r;
  logic [IDX_W-1:0]       hit_idx_r;
  logic [SEQ_W-1:0]       hit_seq_r;
  logic [TIME_W-1:0]      hit_time_r;
  logic [IDX_W-1:0]       free_idx_r;
  logic [CNT_W-1:0]       purged_r;
  logic [CNT_W-1:0]       live_r;

  logic                   issue;
  logic [KEY_W-1:0]       e_key;
  logic [SEQ_W-1:0]       e_seq;
  logic [TIME_W-1:0]      e_time;
  logic [DLY_W-1:0]       age_diff;
  logic                   e_valid;
  logic                   purge;
  logic                   e_live;

  assign issue = scan_r && (iss_cnt_r != CNT_W'(TABLE_DEPTH));

  assign {e_key, e_seq, e_time} = rd_data_r;
  assign e_valid  = valid_r[pidx_r];
  // rcv_time >= entry_time and the distance reaches the age limit
  assign age_diff = {1'b0, rcv_time} - {1'b0, e_time};
  assign purge    = e_valid && !age_diff[DLY_W-1] &&
                    (age_diff[TIME_W-1:0] >= {{(TIME_W-CFG_W){1'b0}}, age_limit});
  assign e_live   = e_valid && !purge;

  // Entry memory, one read port for the scan and one write port.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_idx] <= {key, wr_seq, wr_time};
    end
    if (issue) begin
      rd_data_r <= mem[iss_cnt_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (pend_r && purge) begin
        valid_r[pidx_r] <= 1'b0;
      end
      if (ctl.wr_en) begin
        valid_r[wr_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r    <= 1'b0;
      iss_cnt_r <= '0;
      pend_r    <= 1'b0;
      hit_r     <= 1'b0;
      free_r    <= 1'b0;
      purged_r  <= '0;
      live_r    <= '0;
    end else if (ctl.start) begin
      scan_r    <= 1'b1;
      iss_cnt_r <= '0;
      pend_r    <= 1'b0;
      hit_r     <= 1'b0;
      free_r    <= 1'b0;
      purged_r  <= '0;
      live_r    <= '0;
    end else begin
      pend_r <= issue;
      if (issue) begin
        iss_cnt_r <= iss_cnt_r + CNT_W'(1);
      end
      if (scan_r && !issue && !pend_r) begin
        scan_r <= 1'b0;
      end
      if (pend_r) begin
        if (purge) begin
          purged_r <= purged_r + CNT_W'(1);
        end
        if (e_live) begin
          live_r <= live_r + CNT_W'(1);
          if (!hit_r && (e_key == key)) begin
            hit_r <= 1'b1;
          end
        end else if (!free_r) begin
          free_r <= 1'b1;
        end
      end
    end
  end

  // Payload of the matching and the free slot.
  always_ff @(posedge clk) begin
    if (issue) begin
      pidx_r <= iss_cnt_r[IDX_W-1:0];
    end
    if (pend_r && e_live && !hit_r && (e_key == key)) begin
      hit_idx_r  <= pidx_r;
      hit_seq_r  <= e_seq;
      hit_time_r <= e_time;
    end
    if (pend_r && !e_live && !free_r) begin
      free_idx_r <= pidx_r;
    end
  end

  assign stat.busy = scan_r;
  assign stat.hit  = hit_r;
  assign stat.free = free_r;
  assign hit_idx   = hit_idx_r;
  assign hit_seq   = hit_seq_r;
  assign hit_time  = hit_time_r;
  assign free_idx  = free_idx_r;
  assign purged    = purged_r;
  assign live      = live_r;

endmodule

// ----- rtl/core/ssm_checker.sv -----
// Checker on the result port of the monitor, with its bind.
`include "assert_macros.svh"

module ssm_checker import ssm_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [2:0]           status,
  input logic                 updated,
  input logic [DLY_W-1:0]     transit_delay,
  input logic [DLY_W-1:0]     inter_delay,
  input logic                 transit_late,
  input logic                 inter_late,
  input logic [CNT_OUT_W-1:0] connections
);

  `SSM_ASSERT_ALWAYS(a_rst_idle, clk, !rst_n |=> !out_valid, "result valid after reset")

  `SSM_ASSERT(a_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(status) && $stable(transit_delay) && $stable(connections), "stalled result changed")

  `SSM_ASSERT(a_noupd_zero, clk, rst_n, out_valid && !updated |-> transit_delay == '0 && inter_delay == '0 && !transit_late && !inter_late, "delays reported without update")

  `SSM_ASSERT(a_no_store, clk, rst_n, out_valid && (status == ST_DUP || status == ST_BACK || status == ST_FULL) |-> !updated, "rejected transaction stored")

  `SSM_ASSERT(a_first, clk, rst_n, out_valid && status == ST_FIRST |-> updated && connections == 5'd1 && inter_delay == '0 && !transit_late, "bad first entry result")

endmodule

bind sender_sequence_monitor ssm_checker u_ssm_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_res.valid),
  .out_ready     (out_res.ready),
  .status        (out_res.status),
  .updated       (out_res.updated),
  .transit_delay (out_res.transit_delay),
  .inter_delay   (out_res.inter_delay),
  .transit_late  (out_res.transit_late),
  .inter_late    (out_res.inter_late),
  .connections   (out_res.connections)
);

// ----- tb/sender_sequence_monitor_test.sv -----
// Self-checking testbench for the per-sender sequence and delay monitor.
module sender_sequence_monitor_test import ssm_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH         = 16;
  localparam int POOL          = 20;    // more senders than slots, so the table can fill
  localparam int SETTLE_CYCLES = 2 * (DEPTH + 5);
  localparam int HOLD_CYCLES   = 400;

  // One message header as offered on in_msg.
  typedef struct {
    logic [ID_W-1:0]   sender_id;
    logic [SEQ_W-1:0]  seq_number;
    logic [TIME_W-1:0] msg_time;
    logic [TIME_W-1:0] rcv_time;
  } header_t;

  // One classification result as seen on out_res.
  typedef struct {
    status_t              status;
    logic                 updated;
    logic [DLY_W-1:0]     transit_delay;
    logic [DLY_W-1:0]     inter_delay;
    logic                 transit_late;
    logic                 inter_late;
    logic [CNT_OUT_W-1:0] purged_count;
    logic [CNT_OUT_W-1:0] connections;
  } verdict_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  ssm_in_if  in_if ();
  ssm_out_if out_if ();

  sender_sequence_monitor #(
    .TABLE_DEPTH(DEPTH),
    .ID_BITS    (ID_W)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_msg   (in_if),
    .out_res  (out_if),
    .cfg_wr_en(cfg_wr_en),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Connection table mirror and limits, updated as each transaction is accepted
  // ---------------------------------------------------------------------------
  bit                conn_live  [DEPTH];
  logic [ID_W-1:0]   conn_id    [DEPTH];
  logic [SEQ_W-1:0]  conn_seq   [DEPTH];
  logic [TIME_W-1:0] conn_stamp [DEPTH];
  logic [CFG_W-1:0]  lim_inter;
  logic [CFG_W-1:0]  lim_transit;
  logic [CFG_W-1:0]  lim_age;

  header_t  pending_headers[$];     // waiting for the driver
  verdict_t expected_verdicts[$];   // accepted, result not yet seen
  header_t  offered;                // header currently on in_msg

  int unsigned sender_idle_pct;
  int unsigned rcv_stall_pct;
  bit          hold_off = 1'b0;
  event        hold_start;
  int unsigned mismatches;
  int unsigned results_seen;

  // Stimulus-side view of the senders: ids and the last "good" sequence sent.
  logic [ID_W-1:0]   pool_id [POOL];
  logic [SEQ_W-1:0]  seq_of  [POOL];
  logic [TIME_W-1:0] wall;          // local receive clock, microseconds

  // Aging first, then lookup, then classify / insert.
  function automatic verdict_t judge_header(header_t h);
    verdict_t v;
    int       hit;
    int       slot;
    int       live;
    int       purged;
    longint   seq_diff;
    longint   transit;
    longint   inter;
    longint   rt;
    longint   mt;
    longint   lt;
    longint   li;
    v.status        = ST_OK;
    v.updated       = 1'b0;
    v.transit_delay = '0;
    v.inter_delay   = '0;
    v.transit_late  = 1'b0;
    v.inter_late    = 1'b0;
    hit    = -1;
    slot   = -1;
    live   = 0;
    purged = 0;
    rt     = h.rcv_time;
    mt     = h.msg_time;
    lt     = lim_transit;
    li     = lim_inter;

    // entries stamped in the future never age out
    for (int i = 0; i < DEPTH; i++) begin
      if (conn_live[i] && h.rcv_time >= conn_stamp[i] &&
          (h.rcv_time - conn_stamp[i]) >= lim_age) begin
        conn_live[i] = 1'b0;
        purged++;
      end
    end
    for (int i = 0; i < DEPTH; i++) begin
      if (conn_live[i]) begin
        live++;
        if (hit < 0 && conn_id[i] == h.sender_id) hit = i;
      end else if (slot < 0) begin
        slot = i;
      end
    end

    if (hit >= 0) begin
      // exact difference, no wrap of the 31-bit number
      seq_diff = longint'({33'b0, h.seq_number}) - longint'({33'b0, conn_seq[hit]});
      if (seq_diff == 1)      v.status = ST_OK;
      else if (seq_diff == 0) v.status = ST_DUP;
      else if (seq_diff < 0)  v.status = ST_BACK;
      else                    v.status = ST_GAP;
      if (v.status == ST_OK || v.status == ST_GAP) begin
        transit           = rt - mt;
        inter             = mt - longint'({16'b0, conn_stamp[hit]});
        v.transit_delay   = transit[DLY_W-1:0];
        v.inter_delay     = inter[DLY_W-1:0];
        v.transit_late    = transit > lt;
        v.inter_late      = inter > li;
        conn_seq[hit]     = h.seq_number;
        conn_stamp[hit]   = h.msg_time;
        v.updated         = 1'b1;
      end
    end else if (slot < 0) begin
      v.status = ST_FULL;
    end else begin
      if (live == 0) begin
        // first connection into an empty table is taken unchecked
        v.status = ST_FIRST;
      end else begin
        v.status        = (h.seq_number == 1) ? ST_OK : ST_GAP;
        transit         = rt - mt;
        v.transit_delay = transit[DLY_W-1:0];
        v.transit_late  = transit > lt;
      end
      conn_live[slot]  = 1'b1;
      conn_id[slot]    = h.sender_id;
      conn_seq[slot]   = h.seq_number;
      conn_stamp[slot] = h.msg_time;
      live++;
      v.updated = 1'b1;
    end
    v.purged_count = CNT_OUT_W'(purged);
    v.connections  = CNT_OUT_W'(live);
    return v;
  endfunction

  task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    $display("[%0t] result %0d: %s is %0h, predicted %0h", $realtime, results_seen, what,
             got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers queued headers, predicts each one when it is accepted
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : feed
    header_t nxt;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) expected_verdicts.push_back(judge_header(offered));
      // a held transaction stays put until the block takes it
      if (!in_if.valid || in_if.ready) begin
        if (pending_headers.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          nxt                = pending_headers.pop_front();
          offered            = nxt;
          in_if.valid       <= 1'b1;
          in_if.sender_id   <= nxt.sender_id;
          in_if.seq_number  <= nxt.seq_number;
          in_if.msg_time    <= nxt.msg_time;
          in_if.rcv_time    <= nxt.rcv_time;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random back-pressure, field-by-field compare against the oldest
  // prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : collect
    verdict_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        if (expected_verdicts.size() == 0) begin
          flag_mismatch("unexpected result, status", 64'(out_if.status), 64'd0);
        end else begin
          want = expected_verdicts.pop_front();
          if (out_if.status !== want.status)
            flag_mismatch("status", 64'(out_if.status), 64'(want.status));
          if (out_if.updated !== want.updated)
            flag_mismatch("updated", 64'(out_if.updated), 64'(want.updated));
          if (out_if.transit_delay !== want.transit_delay)
            flag_mismatch("transit_delay", 64'(out_if.transit_delay), 64'(want.transit_delay));
          if (out_if.inter_delay !== want.inter_delay)
            flag_mismatch("inter_delay", 64'(out_if.inter_delay), 64'(want.inter_delay));
          if (out_if.transit_late !== want.transit_late)
            flag_mismatch("transit_late", 64'(out_if.transit_late), 64'(want.transit_late));
          if (out_if.inter_late !== want.inter_late)
            flag_mismatch("inter_late", 64'(out_if.inter_late), 64'(want.inter_late));
          if (out_if.purged_count !== want.purged_count)
            flag_mismatch("purged_count", 64'(out_if.purged_count), 64'(want.purged_count));
          if (out_if.connections !== want.connections)
            flag_mismatch("connections", 64'(out_if.connections), 64'(want.connections));
        end
      end
      out_if.ready <= !hold_off && ($urandom_range(0, 99) >= rcv_stall_pct);
    end
  end

  // Long receiver hold-off: the block keeps one result and stops taking input
  // while the driver keeps offering.
  initial begin : receiver_hold
    forever begin
      @(hold_start);
      hold_off = 1'b1;
      repeat (HOLD_CYCLES) @(negedge clk);
      hold_off = 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_header(logic [ID_W-1:0] id, logic [SEQ_W-1:0] seq,
                              logic [TIME_W-1:0] mt, logic [TIME_W-1:0] rt);
    header_t h;
    h.sender_id  = id;
    h.seq_number = seq;
    h.msg_time   = mt;
    h.rcv_time   = rt;
    pending_headers.push_back(h);
  endtask

  // Block idle: nothing queued, nothing on the wire, every result back.
  task automatic settle();
    while (pending_headers.size() != 0 || in_if.valid || expected_verdicts.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Only called while idle, so the mirror may change at once.
  task automatic apply_limits(logic [CFG_W-1:0] inter, logic [CFG_W-1:0] transit,
                              logic [CFG_W-1:0] age);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_idx   <= REG_INTER_LIMIT;
    cfg_wdata <= inter;
    lim_inter  = inter;
    @(posedge clk);
    cfg_idx   <= REG_TRANSIT_LIMIT;
    cfg_wdata <= transit;
    lim_transit = transit;
    @(posedge clk);
    cfg_idx   <= REG_AGE_LIMIT;
    cfg_wdata <= age;
    lim_age    = age;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // Spread around a limit: tiny, right at it, below it, twice it.
  function automatic longint unsigned span_near(logic [CFG_W-1:0] lim);
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 50);
      1: return (lim < 3) ? 64'($urandom_range(0, 4)) : 64'(lim) - 2 + $urandom_range(0, 4);
      2: return 64'($urandom) % (64'(lim) + 1);
      default: return 64'(lim) * 2;
    endcase
  endfunction

  // Mostly in-order, with duplicates, rewinds, gaps and the odd wild jump.
  function automatic logic [SEQ_W-1:0] next_seq(int k);
    int unsigned      pick;
    logic [SEQ_W-1:0] s;
    pick = $urandom_range(0, 99);
    if (pick < 70)      s = seq_of[k] + 1;
    else if (pick < 78) s = seq_of[k];
    else if (pick < 86) s = seq_of[k] - SEQ_W'($urandom_range(1, 5));
    else if (pick < 97) s = seq_of[k] + SEQ_W'($urandom_range(2, 9));
    else                s = SEQ_W'($urandom);
    if (pick < 70 || pick >= 86) seq_of[k] = s;
    return s;
  endfunction

  task automatic new_pool();
    for (int k = 0; k < POOL; k++) begin
      pool_id[k] = $urandom;
      seq_of[k]  = SEQ_W'($urandom_range(0, 3));
    end
  endtask

  // Well-formed traffic from the sender pool on an advancing clock, plus ~8%
  // fully random headers.
  task automatic run_traffic(int unsigned count);
    int               k;
    logic [TIME_W-1:0] mt;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 8) begin
        queue_header($urandom, SEQ_W'($urandom), TIME_W'({$urandom, $urandom}),
                     TIME_W'({$urandom, $urandom}));
      end else begin
        k = $urandom_range(0, POOL - 1);
        // occasional jump on the order of the age limit purges idle senders
        if ($urandom_range(0, 39) == 0) wall = wall + TIME_W'(span_near(lim_age));
        else                            wall = wall + TIME_W'(span_near(lim_inter) / 16);
        if ($urandom_range(0, 9) == 0) mt = wall + TIME_W'($urandom_range(0, 1000));
        else                           mt = wall - TIME_W'(span_near(lim_transit));
        queue_header(pool_id[k], next_seq(k), mt, wall);
      end
    end
  endtask

  task automatic run_phase(int unsigned idle, int unsigned stall, logic [CFG_W-1:0] inter,
                           logic [CFG_W-1:0] transit, logic [CFG_W-1:0] age,
                           int unsigned count);
    apply_limits(inter, transit, age);
    sender_idle_pct = idle;
    rcv_stall_pct   = stall;
    new_pool();
    run_traffic(count);
    settle();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  localparam logic [TIME_W-1:0] T0       = 48'd5_000_000_000;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam logic [SEQ_W-1:0]  SEQ_MAX  = '1;

  initial begin : stimulus
    rst_n             = 1'b0;
    cfg_wr_en         = 1'b0;
    cfg_idx           = REG_INTER_LIMIT;
    cfg_wdata         = '0;
    in_if.valid       = 1'b0;
    in_if.sender_id   = '0;
    in_if.seq_number  = '0;
    in_if.msg_time    = '0;
    in_if.rcv_time    = '0;
    out_if.ready      = 1'b0;
    sender_idle_pct   = 0;
    rcv_stall_pct     = 0;
    mismatches        = 0;
    results_seen      = 0;
    lim_inter         = INTER_LIMIT_RST;
    lim_transit       = TRANSIT_LIMIT_RST;
    lim_age           = AGE_LIMIT_RST;
    for (int i = 0; i < DEPTH; i++) conn_live[i] = 1'b0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, reset limits (100 ms delays, 10 s age).
    queue_header(32'h0, 0, T0, T0);                          // first into empty table
    queue_header(32'h0, 1, T0 + 10, T0 + 20);                // in order
    queue_header(32'h0, 1, T0 + 30, T0 + 40);                // duplicate
    queue_header(32'h0, 0, T0 + 30, T0 + 40);                // backwards
    queue_header(32'h0, SEQ_MAX, T0 + 300_000, T0 + 100);    // gap, negative transit, late
    queue_header(32'hFFFF_FFFF, 1, T0, T0 + 200_000);        // new sender at seq 1, late
    for (int i = 1; i <= 14; i++)                            // new senders, gap, fill up
      queue_header(ID_W'(i), SEQ_W'(i + 1), T0, T0);
    queue_header(32'd15, 1, T0, T0);                         // table full
    queue_header(32'h0, 0, 48'd0, T0 + 20_000_000);          // purge all sixteen
    queue_header(32'h5A5A_5A5A, 1, TIME_MAX, 48'd0);         // extreme negative transit
    queue_header(32'hA5A5_A5A5, SEQ_MAX, 48'd0, TIME_MAX);   // extreme positive transit
    settle();

    wall = 48'h0100_0000_0000 + TIME_W'($urandom);

    // Random phases: idle mix and limit settings change together.
    run_phase(0, 0, $urandom_range(1000, 200_000), $urandom_range(1000, 200_000),
              $urandom_range(1_000_000, 20_000_000), 300);
    run_phase(72, 0, '1, '1, '1, 300);          // widest limits, table fills
    run_phase(0, 72, '0, '0, 32'd1, 300);       // tightest limits, purge on every step
    run_phase(29, 29, INTER_LIMIT_RST, TRANSIT_LIMIT_RST, AGE_LIMIT_RST, 300);

    // Back-pressure: receiver holds off while the driver keeps pushing.
    apply_limits($urandom_range(1000, 200_000), $urandom_range(1000, 200_000),
                 $urandom_range(1_000_000, 20_000_000));
    sender_idle_pct = 0;
    rcv_stall_pct   = 0;
    new_pool();
    -> hold_start;
    run_traffic(40);
    settle();

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin : watchdog
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
